@@ rtl/core/segment_intersection_unit_assert.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the segment intersection unit
// Shared forms of the concurrent checks, clocked on clk and idle in reset.
// -----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sgi_pkg.sv @@
// -----------------------------------------------------------------------------
// Segment intersection unit package
// Operation codes, the operation class passed down the pipeline, and fixed sizes.
// -----------------------------------------------------------------------------
package sgi_pkg;

	localparam int TOL_W = 31;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_SEG   = 2'd0,
		OP_LINE  = 2'd1,
		OP_POINT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic isect;
		logic line_only;
		logic point;
	} op_class_t;

	localparam int CLASS_W = $bits(op_class_t);

endpackage

@@ rtl/core/segment_intersection_unit.sv @@
// -----------------------------------------------------------------------------
// Segment intersection unit
// Takes one word per clock unless in_stall is high and returns one result
// word per input word, in order. Segment-segment and segment-line words
// report the intersection point A + t(B - A), floored and saturated; the
// point test reports only the hit flag. The pipelined restoring dividers
// produce one quotient bit per stage. A four-word queue separates the input
// register from the datapath, so input and output stall independently. The
// tolerance register is written through the cfg channel, which is always
// ready.
// -----------------------------------------------------------------------------
module segment_intersection_unit import sgi_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [TOL_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [COORD_WIDTH-1:0] seg_a_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_y,
	input  logic signed [COORD_WIDTH-1:0] other_c_x,
	input  logic signed [COORD_WIDTH-1:0] other_c_y,
	input  logic signed [COORD_WIDTH-1:0] other_d_x,
	input  logic signed [COORD_WIDTH-1:0] other_d_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] cross_x,
	output logic signed [COORD_WIDTH-1:0] cross_y
);

	localparam int W      = COORD_WIDTH;
	localparam int DW     = W + 1;
	localparam int DATA_W = CLASS_W + 1 + 6 * DW + 2 * W;

	logic [TOL_W-1:0]    tol_q;
	logic                f_valid, q_full, q_push, q_pop, q_valid;
	logic [DATA_W-1:0]   q_wdata, q_rdata;
	op_class_t           f_cls, b_cls;
	logic                f_aok, b_aok;
	logic signed [W:0]   f_d1x, f_d1y, f_d2x, f_d2y, f_ex, f_ey;
	logic signed [W:0]   b_d1x, b_d1y, b_d2x, b_d2y, b_ex, b_ey;
	logic signed [W-1:0] f_ax, f_ay, b_ax, b_ay;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	sgi_front #(
		.W (W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.tolerance    (tol_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.seg_a_x      (seg_a_x),
		.seg_a_y      (seg_a_y),
		.seg_b_x      (seg_b_x),
		.seg_b_y      (seg_b_y),
		.other_c_x    (other_c_x),
		.other_c_y    (other_c_y),
		.other_d_x    (other_d_x),
		.other_d_y    (other_d_y),
		.q_full       (q_full),
		.item_valid   (f_valid),
		.item_cls     (f_cls),
		.item_axis_ok (f_aok),
		.item_d1x     (f_d1x),
		.item_d1y     (f_d1y),
		.item_d2x     (f_d2x),
		.item_d2y     (f_d2y),
		.item_ex      (f_ex),
		.item_ey      (f_ey),
		.item_ax      (f_ax),
		.item_ay      (f_ay)
	);

	assign q_push  = f_valid && !q_full;
	assign q_wdata = {f_cls, f_aok, f_d1x, f_d1y, f_d2x, f_d2y, f_ex, f_ey, f_ax, f_ay};

	sgi_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	assign {b_cls, b_aok, b_d1x, b_d1y, b_d2x, b_d2y, b_ex, b_ey, b_ax, b_ay} = q_rdata;

	sgi_back #(
		.W (W),
		.F (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tolerance (tol_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.b_cls     (b_cls),
		.b_axis_ok (b_aok),
		.b_d1x     (b_d1x),
		.b_d1y     (b_d1y),
		.b_d2x     (b_d2x),
		.b_d2y     (b_d2y),
		.b_ex      (b_ex),
		.b_ey      (b_ey),
		.b_ax      (b_ax),
		.b_ay      (b_ay),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.cross_x   (cross_x),
		.cross_y   (cross_y)
	);

	`include "segment_intersection_unit_assert.svh"

	`SGI_ASSERT_NOW(a_stall_on_full, in_stall, f_valid && q_full, "input stalled without a full queue")
	`SGI_ASSERT_NEXT(a_word_caught, in_valid && !in_stall, f_valid, "accepted word lost at the front")
	`SGI_ASSERT_NOW(a_no_pop_stalled, out_valid && out_stall, !q_pop, "queue popped while output stalled")
	`SGI_ASSERT_NOW(a_miss_zero, out_valid && !hit, cross_x == '0 && cross_y == '0, "point not cleared on a miss")

endmodule

@@ rtl/core/sgi_front.sv @@
// -----------------------------------------------------------------------------
// Segment intersection front end
// Registers each accepted word, forms the direction vectors and runs the
// per-axis bounding checks of the point test.
// -----------------------------------------------------------------------------
module sgi_front import sgi_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TOL_W-1:0]      tolerance,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic signed [W-1:0]   seg_a_x,
	input  logic signed [W-1:0]   seg_a_y,
	input  logic signed [W-1:0]   seg_b_x,
	input  logic signed [W-1:0]   seg_b_y,
	input  logic signed [W-1:0]   other_c_x,
	input  logic signed [W-1:0]   other_c_y,
	input  logic signed [W-1:0]   other_d_x,
	input  logic signed [W-1:0]   other_d_y,
	input  logic                  q_full,
	output logic                  item_valid,
	output op_class_t             item_cls,
	output logic                  item_axis_ok,
	output logic signed [W:0]     item_d1x,
	output logic signed [W:0]     item_d1y,
	output logic signed [W:0]     item_d2x,
	output logic signed [W:0]     item_d2y,
	output logic signed [W:0]     item_ex,
	output logic signed [W:0]     item_ey,
	output logic signed [W-1:0]   item_ax,
	output logic signed [W-1:0]   item_ay
);

	localparam int DW = W + 1;
	localparam int CW = ((DW > TOL_W) ? DW : TOL_W) + 1;

	logic      v_s1;
	op_class_t cls_w;
	logic      take;

	function automatic logic near(input logic signed [DW-1:0] diff,
			input logic [TOL_W-1:0] tol);
		logic [DW-1:0] mag;
		mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
		return CW'(mag) < CW'(tol);
	endfunction

	function automatic logic axis_ok(input logic signed [W-1:0] p,
			input logic signed [W-1:0] a, input logic signed [W-1:0] b,
			input logic [TOL_W-1:0] tol);
		logic signed [DW-1:0] dpa;
		logic signed [DW-1:0] dpb;
		logic ge_a, le_a, ge_b, le_b;
		dpa = DW'(p) - DW'(a);
		dpb = DW'(p) - DW'(b);
		ge_a = !dpa[DW-1] || near(dpa, tol);
		le_a = dpa[DW-1] || (dpa == '0) || near(dpa, tol);
		ge_b = !dpb[DW-1] || near(dpb, tol);
		le_b = dpb[DW-1] || (dpb == '0) || near(dpb, tol);
		return (ge_a && le_b) || (ge_b && le_a);
	endfunction

	assign in_stall   = v_s1 && q_full;
	assign take       = in_valid && !in_stall;
	assign item_valid = v_s1;

	always_comb begin
		cls_w = '0;
		case (op_t'(op))
			OP_SEG: begin
				cls_w.isect = 1'b1;
			end
			OP_LINE: begin
				cls_w.isect     = 1'b1;
				cls_w.line_only = 1'b1;
			end
			OP_POINT: begin
				cls_w.point = 1'b1;
			end
			default: begin
				cls_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_cls     <= cls_w;
			item_axis_ok <= axis_ok(other_c_x, seg_a_x, seg_b_x, tolerance)
				&& axis_ok(other_c_y, seg_a_y, seg_b_y, tolerance);
			item_d1x     <= DW'(seg_b_x) - DW'(seg_a_x);
			item_d1y     <= DW'(seg_b_y) - DW'(seg_a_y);
			item_d2x     <= DW'(other_d_x) - DW'(other_c_x);
			item_d2y     <= DW'(other_d_y) - DW'(other_c_y);
			item_ex      <= DW'(seg_a_x) - DW'(other_c_x);
			item_ey      <= DW'(seg_a_y) - DW'(other_c_y);
			item_ax      <= seg_a_x;
			item_ay      <= seg_a_y;
		end
	end

endmodule

@@ rtl/core/sgi_queue.sv @@
// -----------------------------------------------------------------------------
// Segment intersection decoupling queue
// A short first-in first-out store between the front end and the datapath.
// -----------------------------------------------------------------------------
module sgi_queue import sgi_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              not_empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0] mem [0:QUEUE_DEPTH-1];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;

	assign full      = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/sgi_div.sv @@
// -----------------------------------------------------------------------------
// Segment intersection pipelined divider
// Restoring division of unsigned magnitudes, one quotient bit per stage.
// -----------------------------------------------------------------------------
module sgi_div #(
	parameter int NUM_W  = 98,
	parameter int DEN_W  = 66,
	parameter int QUO_W  = 49,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic              rem_nz,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = DEN_W + 1;

	logic              v_s    [1:QUO_W];
	logic [RW-1:0]     rem_s  [1:QUO_W];
	logic [QUO_W-1:0]  low_s  [1:QUO_W];
	logic [DEN_W-1:0]  den_s  [1:QUO_W];
	logic [SIDE_W-1:0] side_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic              v_in;
		logic [RW-1:0]     rem_in;
		logic [QUO_W-1:0]  low_in;
		logic [DEN_W-1:0]  den_in;
		logic [SIDE_W-1:0] side_in;
		logic [RW-1:0]     trial;
		logic [RW:0]       diff;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = RW'(num[NUM_W-1:QUO_W]);
			assign low_in  = num[QUO_W-1:0];
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = v_s[k];
			assign rem_in  = rem_s[k];
			assign low_in  = low_s[k];
			assign den_in  = den_s[k];
			assign side_in = side_s[k];
		end

		assign trial = {rem_in[RW-2:0], low_in[QUO_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= diff[RW] ? trial : diff[RW-1:0];
				low_s[k+1]  <= {low_in[QUO_W-2:0], !diff[RW]};
				den_s[k+1]  <= den_in;
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quo       = low_s[QUO_W];
	assign rem_nz    = |rem_s[QUO_W];
	assign side_out  = side_s[QUO_W];

endmodule

@@ rtl/core/sgi_back.sv @@
// -----------------------------------------------------------------------------
// Segment intersection datapath
// Cross products, parameter range checks, the point test, the intersection
// point by floor division, saturation and the output register.
// -----------------------------------------------------------------------------
module sgi_back import sgi_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TOL_W-1:0]      tolerance,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  op_class_t             b_cls,
	input  logic                  b_axis_ok,
	input  logic signed [W:0]     b_d1x,
	input  logic signed [W:0]     b_d1y,
	input  logic signed [W:0]     b_d2x,
	input  logic signed [W:0]     b_d2y,
	input  logic signed [W:0]     b_ex,
	input  logic signed [W:0]     b_ey,
	input  logic signed [W-1:0]   b_ax,
	input  logic signed [W-1:0]   b_ay,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic signed [W-1:0]   cross_x,
	output logic signed [W-1:0]   cross_y
);

	localparam int DW  = W + 1;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	localparam int MW  = NW + TOL_W + 2;
	localparam int LOB = DW + 1;
	localparam int XW  = NW + DW;
	localparam int QW  = W + 33 - F;
	localparam int SW  = QW + 2;
	localparam int LW  = (NW > TOL_W + F) ? NW : TOL_W + F + 1;
	localparam int XSIDE_W = 3 + 2 * W;

	logic en;

	// Stage 1: products.
	logic                   v_s1;
	op_class_t              cls_s1;
	logic                   aok_s1;
	logic signed [DW-1:0]   d1x_s1, d1y_s1;
	logic signed [W-1:0]    ax_s1, ay_s1;
	logic signed [PW-1:0]   mda_s1, mdb_s1, mta_s1, mtb_s1, msa_s1, msb_s1;

	// Stage 2: determinants.
	logic                   v_s2;
	op_class_t              cls_s2;
	logic                   aok_s2;
	logic signed [DW-1:0]   d1x_s2, d1y_s2;
	logic signed [W-1:0]    ax_s2, ay_s2;
	logic signed [NW-1:0]   den_s2, tn_s2, sn_s2;

	// Stage 3: sign normalisation.
	logic                   v_s3;
	op_class_t              cls_s3;
	logic                   aok_s3;
	logic signed [DW-1:0]   d1x_s3, d1y_s3;
	logic signed [W-1:0]    ax_s3, ay_s3;
	logic [PW-1:0]          den_s3;
	logic                   dz_s3;
	logic signed [NW-1:0]   tn_s3, sn_s3;
	logic [PW-1:0]          cr_s3;

	// Stage 4: partial products.
	logic                   v_s4;
	op_class_t              cls_s4;
	logic                   aok_s4;
	logic signed [W-1:0]    ax_s4, ay_s4;
	logic [PW-1:0]          den_s4;
	logic                   dz_s4;
	logic signed [NW-1:0]   tn_s4, sn_s4;
	logic                   crok_s4;
	logic [DW+TOL_W-1:0]    pdl_s4, pdh_s4;
	logic signed [LOB+DW:0] txl_s4, tyl_s4;
	logic signed [PW-1:0]   txh_s4, tyh_s4;

	// Stage 5: full products.
	logic                   v_s5;
	op_class_t              cls_s5;
	logic                   aok_s5;
	logic signed [W-1:0]    ax_s5, ay_s5;
	logic [PW-1:0]          den_s5;
	logic                   dz_s5;
	logic signed [NW-1:0]   tn_s5, sn_s5;
	logic                   crok_s5;
	logic [MW-1:0]          pm_s5;
	logic signed [XW-1:0]   px_s5, py_s5;

	// Stage 6: range sums.
	logic                   v_s6;
	op_class_t              cls_s6;
	logic                   aok_s6;
	logic signed [W-1:0]    ax_s6, ay_s6;
	logic [PW-1:0]          den_s6;
	logic                   dz_s6;
	logic                   crok_s6;
	logic signed [MW-1:0]   tlo_s6, thi_s6, slo_s6, shi_s6;
	logic [MW-1:0]          dsh_s6;
	logic [XW-2:0]          nx_s6, ny_s6;
	logic                   negx_s6, negy_s6;

	// Stage 7: decision and divider feed.
	logic                   v_s7;
	logic                   hit_s7, pen_s7;
	logic signed [W-1:0]    ax_s7, ay_s7;
	logic [PW-1:0]          den_s7;
	logic [XW-2:0]          nx_s7, ny_s7;
	logic                   negx_s7, negy_s7;

	// Stage 8: signed quotients.
	logic                   v_s8;
	logic                   hit_s8, pen_s8;
	logic signed [W-1:0]    ax_s8, ay_s8;
	logic signed [QW:0]     qx_s8, qy_s8;

	logic                   out_valid_q, hit_q;
	logic signed [W-1:0]    cross_x_q, cross_y_q;

	logic signed [NW-1:0]   den_neg_w, tn_neg_w, sn_neg_w;
	logic signed [XW-1:0]   txh_e, txl_e, tyh_e, tyl_e, px_neg_w, py_neg_w;
	logic signed [MW-1:0]   tn_e, sn_e, ns_t, ns_s;
	logic                   t_ok, s_ok;
	logic                   dvx_valid, dvy_valid;
	logic [QW-1:0]          quo_x, quo_y;
	logic                   rnz_x, rnz_y;
	logic [XSIDE_W-1:0]     side_x_out;
	logic                   side_y_out;
	logic                   hit_d, pen_d, negx_d;
	logic signed [W-1:0]    ax_d, ay_d;
	logic signed [SW-1:0]   ax_e, ay_e, qx_e, qy_e, sum_x, sum_y;

	function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
		if ((v[SW-1:W-1] == '0) || (v[SW-1:W-1] == '1)) begin
			return v[W-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	assign en    = !out_valid_q || !out_stall;
	assign q_pop = en && q_valid;

	assign den_neg_w = -den_s2;
	assign tn_neg_w  = -tn_s2;
	assign sn_neg_w  = -sn_s2;

	assign txh_e    = txh_s4;
	assign txl_e    = txl_s4;
	assign tyh_e    = tyh_s4;
	assign tyl_e    = tyl_s4;
	assign px_neg_w = -px_s5;
	assign py_neg_w = -py_s5;

	assign tn_e = tn_s5;
	assign sn_e = sn_s5;
	assign ns_t = tn_e <<< F;
	assign ns_s = sn_e <<< F;

	assign t_ok = !tlo_s6[MW-1] && (thi_s6 <= $signed(dsh_s6));
	assign s_ok = !slo_s6[MW-1] && (shi_s6 <= $signed(dsh_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= dvx_valid;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1 <= b_cls;
			aok_s1 <= b_axis_ok;
			d1x_s1 <= b_d1x;
			d1y_s1 <= b_d1y;
			ax_s1  <= b_ax;
			ay_s1  <= b_ay;
			mda_s1 <= b_d1x * b_d2y;
			mdb_s1 <= b_d2x * b_d1y;
			mta_s1 <= b_d2x * b_ey;
			mtb_s1 <= b_d2y * b_ex;
			msa_s1 <= b_d1x * b_ey;
			msb_s1 <= b_d1y * b_ex;

			cls_s2 <= cls_s1;
			aok_s2 <= aok_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			den_s2 <= mda_s1 - mdb_s1;
			tn_s2  <= mta_s1 - mtb_s1;
			sn_s2  <= msa_s1 - msb_s1;

			cls_s3 <= cls_s2;
			aok_s3 <= aok_s2;
			d1x_s3 <= d1x_s2;
			d1y_s3 <= d1y_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			den_s3 <= den_s2[NW-1] ? den_neg_w[PW-1:0] : den_s2[PW-1:0];
			dz_s3  <= (den_s2 == '0);
			tn_s3  <= den_s2[NW-1] ? tn_neg_w : tn_s2;
			sn_s3  <= den_s2[NW-1] ? sn_neg_w : sn_s2;
			cr_s3  <= sn_s2[NW-1] ? sn_neg_w[PW-1:0] : sn_s2[PW-1:0];

			cls_s4  <= cls_s3;
			aok_s4  <= aok_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			den_s4  <= den_s3;
			dz_s4   <= dz_s3;
			tn_s4   <= tn_s3;
			sn_s4   <= sn_s3;
			crok_s4 <= LW'(cr_s3) < LW'({tolerance, {F{1'b0}}});
			pdl_s4  <= den_s3[DW-1:0] * tolerance;
			pdh_s4  <= den_s3[PW-1:DW] * tolerance;
			txl_s4  <= $signed({1'b0, tn_s3[LOB-1:0]}) * d1x_s3;
			tyl_s4  <= $signed({1'b0, tn_s3[LOB-1:0]}) * d1y_s3;
			txh_s4  <= $signed(tn_s3[NW-1:LOB]) * d1x_s3;
			tyh_s4  <= $signed(tn_s3[NW-1:LOB]) * d1y_s3;

			cls_s5  <= cls_s4;
			aok_s5  <= aok_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			den_s5  <= den_s4;
			dz_s5   <= dz_s4;
			tn_s5   <= tn_s4;
			sn_s5   <= sn_s4;
			crok_s5 <= crok_s4;
			pm_s5   <= (MW'(pdh_s4) << DW) + MW'(pdl_s4);
			px_s5   <= (txh_e <<< LOB) + txl_e;
			py_s5   <= (tyh_e <<< LOB) + tyl_e;

			cls_s6  <= cls_s5;
			aok_s6  <= aok_s5;
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
			den_s6  <= den_s5;
			dz_s6   <= dz_s5;
			crok_s6 <= crok_s5;
			tlo_s6  <= ns_t + $signed(pm_s5);
			thi_s6  <= ns_t - $signed(pm_s5);
			slo_s6  <= ns_s + $signed(pm_s5);
			shi_s6  <= ns_s - $signed(pm_s5);
			dsh_s6  <= MW'(den_s5) << F;
			negx_s6 <= px_s5[XW-1];
			negy_s6 <= py_s5[XW-1];
			nx_s6   <= px_s5[XW-1] ? px_neg_w[XW-2:0] : px_s5[XW-2:0];
			ny_s6   <= py_s5[XW-1] ? py_neg_w[XW-2:0] : py_s5[XW-2:0];

			if (cls_s6.point) begin
				hit_s7 <= aok_s6 && crok_s6;
			end else if (cls_s6.isect) begin
				hit_s7 <= !dz_s6 && t_ok && (cls_s6.line_only || s_ok);
			end else begin
				hit_s7 <= 1'b0;
			end
			pen_s7  <= cls_s6.isect;
			ax_s7   <= ax_s6;
			ay_s7   <= ay_s6;
			den_s7  <= den_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;

			hit_s8 <= hit_d;
			pen_s8 <= pen_d;
			ax_s8  <= ax_d;
			ay_s8  <= ay_d;
			qx_s8  <= negx_d ? $signed(~{1'b0, quo_x}) + $signed({{QW{1'b0}}, !rnz_x})
				: $signed({1'b0, quo_x});
			qy_s8  <= side_y_out ? $signed(~{1'b0, quo_y}) + $signed({{QW{1'b0}}, !rnz_y})
				: $signed({1'b0, quo_y});

			hit_q     <= hit_s8;
			cross_x_q <= (hit_s8 && pen_s8) ? sat(sum_x) : '0;
			cross_y_q <= (hit_s8 && pen_s8) ? sat(sum_y) : '0;
		end
	end

	sgi_div #(
		.NUM_W  (XW - 1),
		.DEN_W  (PW),
		.QUO_W  (QW),
		.SIDE_W (XSIDE_W)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (nx_s7),
		.den       (den_s7),
		.side      ({hit_s7, pen_s7, negx_s7, ax_s7, ay_s7}),
		.out_valid (dvx_valid),
		.quo       (quo_x),
		.rem_nz    (rnz_x),
		.side_out  (side_x_out)
	);

	sgi_div #(
		.NUM_W  (XW - 1),
		.DEN_W  (PW),
		.QUO_W  (QW),
		.SIDE_W (1)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (ny_s7),
		.den       (den_s7),
		.side      (negy_s7),
		.out_valid (dvy_valid),
		.quo       (quo_y),
		.rem_nz    (rnz_y),
		.side_out  (side_y_out)
	);

	assign {hit_d, pen_d, negx_d, ax_d, ay_d} = side_x_out;

	assign ax_e  = ax_s8;
	assign ay_e  = ay_s8;
	assign qx_e  = qx_s8;
	assign qy_e  = qy_s8;
	assign sum_x = ax_e + qx_e;
	assign sum_y = ay_e + qy_e;

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;

	`include "segment_intersection_unit_assert.svh"

	`SGI_ASSERT_NOW(a_div_lockstep, dvx_valid || dvy_valid, dvx_valid && dvy_valid, "dividers out of step")

endmodule
